### src/qse_pkg.sv
package qse_pkg;

  // Capacity of the element store and the widths that follow from it.
  localparam int MAX_ITEMS = 64;
  localparam int DEPTH     = 64;
  localparam int ADDR_W    = 6;
  localparam int CNT_W     = 7;
  localparam int DATA_W    = 32;
  localparam int ENTRY_W   = 2 * CNT_W;

  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [ENTRY_W-1:0] entry_t;

endpackage

### src/quick_sort_engine.sv
// Channel  | Signals                      | Direction | Transaction
// ---------+------------------------------+-----------+---------------------------------
// input    | start, busy, value, last     | in        | start high while busy is low
// result   | strobe, value_res, last_res  | out       | every cycle with strobe high
//
// Loading accepts one item per cycle, with busy low throughout.
// The item marked last starts the sort: each partition reads an element (RDJ) and
// compares it (CMP) through the single read port of the element store, and each
// swap writes both slots in turn (SWJ, SWI) on its single write port. Results
// then follow, each read (ORD), then presented (OEM); busy falls the cycle
// after the final result. Synchronous reset empties the set and returns to
// loading. The receiver cannot stall results.
module quick_sort_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] value,
  input  logic               last,
  output logic               strobe,
  output logic signed [31:0] value_res,
  output logic               last_res
);

  // Sequencer state codes.
  localparam logic [3:0] S_LOAD  = 4'd0;
  localparam logic [3:0] S_POP   = 4'd1;
  localparam logic [3:0] S_RANGE = 4'd2;
  localparam logic [3:0] S_PIVOT = 4'd3;
  localparam logic [3:0] S_RDJ   = 4'd4;
  localparam logic [3:0] S_CMP   = 4'd5;
  localparam logic [3:0] S_SWJ   = 4'd6;
  localparam logic [3:0] S_SWI   = 4'd7;
  localparam logic [3:0] S_FINA  = 4'd8;
  localparam logic [3:0] S_FINB  = 4'd9;
  localparam logic [3:0] S_PUSHL = 4'd10;
  localparam logic [3:0] S_PUSHR = 4'd11;
  localparam logic [3:0] S_ORD   = 4'd12;
  localparam logic [3:0] S_OEM   = 4'd13;

  localparam qse_pkg::cnt_t ONE = qse_pkg::cnt_t'(1);
  localparam qse_pkg::cnt_t TWO = qse_pkg::cnt_t'(2);
  localparam qse_pkg::cnt_t CAP = qse_pkg::cnt_t'(qse_pkg::MAX_ITEMS);

  // Memories.
  logic signed [qse_pkg::DATA_W-1:0] store [qse_pkg::DEPTH];
  qse_pkg::entry_t                   stack [qse_pkg::DEPTH];

  logic [3:0]                        state;
  qse_pkg::cnt_t                     count;
  qse_pkg::cnt_t                     sp;
  qse_pkg::cnt_t                     lo;
  qse_pkg::cnt_t                     len;
  qse_pkg::cnt_t                     i;
  qse_pkg::cnt_t                     j;
  qse_pkg::cnt_t                     k;
  logic signed [qse_pkg::DATA_W-1:0] pivot;
  logic signed [qse_pkg::DATA_W-1:0] dj;
  logic signed [qse_pkg::DATA_W-1:0] store_rd;
  qse_pkg::entry_t                   stack_rd;

  // Store and stack port controls.
  qse_pkg::addr_t                    st_raddr;
  logic                              st_we;
  qse_pkg::addr_t                    st_waddr;
  logic signed [qse_pkg::DATA_W-1:0] st_wdata;
  qse_pkg::addr_t                    sk_raddr;
  logic                              sk_we;
  qse_pkg::addr_t                    sk_waddr;
  qse_pkg::entry_t                   sk_wdata;

  // Index sums inside the current range.
  qse_pkg::cnt_t sum_j;
  qse_pkg::cnt_t sum_i;
  qse_pkg::cnt_t sum_b;
  qse_pkg::cnt_t sp_dec;
  qse_pkg::cnt_t n_set;
  logic          accept;
  logic          room;
  logic          is_less;

  assign sum_j   = lo + j;
  assign sum_i   = lo + i;
  assign sum_b   = sum_i - ONE;
  assign sp_dec  = sp - ONE;
  assign accept  = start && !busy;
  assign room    = count < CAP;
  assign n_set   = room ? count + ONE : count;
  assign is_less = store_rd < pivot;

  assign busy      = state != S_LOAD;
  assign strobe    = state == S_OEM;
  assign value_res = store_rd;
  assign last_res  = (k + ONE) == count;

  // Port selection for both memories, driven by the sequencer state.
  always_comb begin
    st_raddr = sum_j[qse_pkg::ADDR_W-1:0];
    st_we    = 1'b0;
    st_waddr = sum_j[qse_pkg::ADDR_W-1:0];
    st_wdata = store_rd;
    sk_raddr = sp_dec[qse_pkg::ADDR_W-1:0];
    sk_we    = 1'b0;
    sk_waddr = sp[qse_pkg::ADDR_W-1:0];
    sk_wdata = {lo, i - ONE};
    case (state)
      S_LOAD: begin
        st_we    = accept && room;
        st_waddr = count[qse_pkg::ADDR_W-1:0];
        st_wdata = value;
        sk_we    = accept && last;
        sk_waddr = '0;
        sk_wdata = {qse_pkg::cnt_t'(0), n_set};
      end
      S_RANGE: st_raddr = stack_rd[qse_pkg::CNT_W +: qse_pkg::ADDR_W];
      S_RDJ: begin
        if (j == len) begin
          st_raddr = sum_b[qse_pkg::ADDR_W-1:0];
        end
      end
      S_CMP: st_raddr = sum_i[qse_pkg::ADDR_W-1:0];
      S_SWJ: st_we = 1'b1;
      S_SWI: begin
        st_we    = 1'b1;
        st_waddr = sum_i[qse_pkg::ADDR_W-1:0];
        st_wdata = dj;
      end
      S_FINA: begin
        st_we    = 1'b1;
        st_waddr = lo[qse_pkg::ADDR_W-1:0];
      end
      S_FINB: begin
        st_we    = 1'b1;
        st_waddr = sum_b[qse_pkg::ADDR_W-1:0];
        st_wdata = pivot;
      end
      S_PUSHL: sk_we = (i - ONE) >= TWO;
      S_PUSHR: begin
        sk_we    = (len - i) >= TWO;
        sk_wdata = {sum_i, len - i};
      end
      S_ORD: st_raddr = k[qse_pkg::ADDR_W-1:0];
      default: ;
    endcase
  end

  // Element store: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (st_we) begin
      store[st_waddr] <= st_wdata;
    end
    store_rd <= store[st_raddr];
  end

  // Range stack: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (sk_we) begin
      stack[sk_waddr] <= sk_wdata;
    end
    stack_rd <= stack[sk_raddr];
  end

  // Sequencer: load, partition ranges from the stack, then stream out.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
      sp    <= '0;
      k     <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (accept) begin
            count <= n_set;
            if (last) begin
              sp    <= (n_set >= TWO) ? ONE : '0;
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          if (sp == '0) begin
            k     <= '0;
            state <= S_ORD;
          end else begin
            sp    <= sp_dec;
            state <= S_RANGE;
          end
        end
        S_RANGE: begin
          lo    <= stack_rd[qse_pkg::ENTRY_W-1:qse_pkg::CNT_W];
          len   <= stack_rd[qse_pkg::CNT_W-1:0];
          state <= (stack_rd[qse_pkg::CNT_W-1:0] < TWO) ? S_POP : S_PIVOT;
        end
        S_PIVOT: begin
          pivot <= store_rd;
          i     <= ONE;
          j     <= ONE;
          state <= S_RDJ;
        end
        S_RDJ: begin
          if (j == len) begin
            state <= (i == ONE) ? S_PUSHL : S_FINA;
          end else begin
            state <= S_CMP;
          end
        end
        S_CMP: begin
          dj <= store_rd;
          if (is_less && (i != j)) begin
            state <= S_SWJ;
          end else begin
            j <= j + ONE;
            if (is_less) begin
              i <= i + ONE;
            end
            state <= S_RDJ;
          end
        end
        S_SWJ: begin
          // The slot at j takes the element from i this cycle; j moves on after it.
          j     <= j + ONE;
          state <= S_SWI;
        end
        S_SWI: begin
          i     <= i + ONE;
          state <= S_RDJ;
        end
        S_FINA:  state <= S_FINB;
        S_FINB:  state <= S_PUSHL;
        S_PUSHL: begin
          if ((i - ONE) >= TWO) begin
            sp <= sp + ONE;
          end
          state <= S_PUSHR;
        end
        S_PUSHR: begin
          if ((len - i) >= TWO) begin
            sp <= sp + ONE;
          end
          state <= S_POP;
        end
        S_ORD:   state <= S_OEM;
        S_OEM: begin
          k <= k + ONE;
          if (last_res) begin
            count <= '0;
            state <= S_LOAD;
          end else begin
            state <= S_ORD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // The store never holds more than its capacity.
  assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("element count beyond capacity");

  // Pending ranges are disjoint, so the stack cannot exceed the store depth.
  assert property (@(posedge clk) disable iff (rst) sp <= CAP)
    else $error("range stack overflow");

  // A result never appears while the block is taking input.
  assert property (@(posedge clk) disable iff (rst) strobe |-> busy)
    else $error("result strobe while loading");

  // The final result returns the block to loading with an empty set.
  assert property (@(posedge clk) disable iff (rst)
                   strobe && last_res |=> !busy && count == '0)
    else $error("block did not return to loading after the final result");

  // The partition indices stay inside the current range.
  assert property (@(posedge clk) disable iff (rst)
                   (state == S_RDJ) |-> (i <= j && j <= len))
    else $error("partition index outside range");

endmodule

### bench/tb_quick_sort_engine.sv
module tb_quick_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int          SETTLE_TICKS = 20;
  localparam int          SHOWN_ERRORS = 10;

  // One sorted value as it should appear on the result ports.
  typedef struct packed {
    logic signed [qse_pkg::DATA_W-1:0] value;
    logic                              last;
  } sorted_t;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              start = 1'b0;
  logic signed [qse_pkg::DATA_W-1:0] value = '0;
  logic                              last = 1'b0;
  logic                              busy;
  logic                              strobe;
  logic signed [qse_pkg::DATA_W-1:0] value_res;
  logic                              last_res;

  // Set being collected by the predictor, and sorted values still owed by the block.
  logic signed [qse_pkg::DATA_W-1:0] gathered_set[$];
  sorted_t                           sorted_due[$];
  sorted_t                           head;

  int          idle_pct = 0;
  int          fail_count = 0;
  int          sets_sent = 0;
  int          items_sent = 0;
  int          values_seen = 0;
  int unsigned cycle_count = 0;

  always #2 clk = ~clk;

  quick_sort_engine u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .value     (value),
    .last      (last),
    .strobe    (strobe),
    .value_res (value_res),
    .last_res  (last_res)
  );

  // Predictor: keep up to MAX_ITEMS values; the final item releases them in ascending order.
  task automatic gather_and_sort(input logic signed [qse_pkg::DATA_W-1:0] v, input logic l);
    logic signed [qse_pkg::DATA_W-1:0] ordered[$];
    logic signed [qse_pkg::DATA_W-1:0] key;
    int                                a;
    int                                b;
    sorted_t                           entry;
    if (gathered_set.size() < qse_pkg::MAX_ITEMS) begin
      gathered_set.push_back(v);
    end
    if (l) begin
      ordered = gathered_set;
      // Insertion sort on signed values.
      for (a = 1; a < ordered.size(); a++) begin
        key = ordered[a];
        b = a - 1;
        while (b >= 0 && ordered[b] > key) begin
          ordered[b + 1] = ordered[b];
          b--;
        end
        ordered[b + 1] = key;
      end
      for (a = 0; a < ordered.size(); a++) begin
        entry.value = ordered[a];
        entry.last  = (a == ordered.size() - 1);
        sorted_due.push_back(entry);
      end
      gathered_set.delete();
      sets_sent++;
    end
  endtask

  // Offer one item, after a random number of idle cycles, and hold it until it is taken.
  task automatic send_item(input logic signed [qse_pkg::DATA_W-1:0] v, input logic l);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      value <= $urandom;
      last  <= 1'($urandom_range(1));
    end
    @(negedge clk);
    start <= 1'b1;
    value <= v;
    last  <= l;
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
    gather_and_sort(v, l);
    items_sent++;
  endtask

  // Stop offering items until every owed value has come back, then let the block settle.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    last  <= 1'b0;
    while (sorted_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  // Mix of full-range values, a narrow band that gives duplicates, and the extremes.
  function automatic logic signed [qse_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(3))
      0, 1: return $urandom;
      2: return $signed($urandom_range(16)) - 8;
      default: begin
        case ($urandom_range(3))
          0: return 32'sh8000_0000;
          1: return 32'sh7FFF_FFFF;
          2: return 32'sh0000_0000;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic send_set(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      send_item(pick_value(), k == count - 1);
    end
  endtask

  task automatic test_reset();
    rst <= 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  endtask

  // Single-item sets, the extremes, duplicates and already ordered input.
  task automatic test_directed();
    idle_pct = 0;
    send_item(32'sh8000_0000, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b1);
    send_item(32'sh7FFF_FFFF, 1'b0);
    send_item(32'sh8000_0000, 1'b0);
    send_item(32'sh0000_0000, 1'b0);
    send_item(-32'sd1, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sh5555_5555, 1'b0);
    send_item(32'shAAAA_AAAA, 1'b1);
    send_item(32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b0);
    send_item(-32'sd5, 1'b0);
    send_item(32'sd5, 1'b1);
    send_item(32'sd3, 1'b0);
    send_item(32'sd2, 1'b0);
    send_item(32'sd1, 1'b0);
    send_item(32'sd0, 1'b1);
    send_item(-32'sd2, 1'b0);
    send_item(32'sd2, 1'b1);
    wait_drained();
  endtask

  // A set that fills the store exactly and then overruns it, so its tail, final item
  // included, is dropped.
  task automatic test_capacity();
    idle_pct = 8;
    send_set(qse_pkg::MAX_ITEMS + 2);
    wait_drained();
  endtask

  // Random sets, mostly short with an occasional longer one.
  task automatic test_random_sets(input int pct, input int budget);
    int first;
    idle_pct = pct;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(9) == 0) begin
        send_set($urandom_range(16, 9));
      end else begin
        send_set($urandom_range(8, 1));
      end
    end
    wait_drained();
  endtask

  // Every strobed result is checked against the oldest owed value.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (sorted_due.size() == 0) begin
        fail_count++;
        if (fail_count <= SHOWN_ERRORS) begin
          $display("Unexpected result transaction: value %0d last %0b", value_res, last_res);
        end
      end else begin
        head = sorted_due.pop_front();
        values_seen++;
        if (value_res !== head.value || last_res !== head.last) begin
          fail_count++;
          if (fail_count <= SHOWN_ERRORS) begin
            $display("Result mismatch: expected value %0d last %0b, got value %0d last %0b",
                     head.value, head.last, value_res, last_res);
          end
        end
      end
    end
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out with %0d sorted values still owed.", sorted_due.size());
      $display("tb_quick_sort_engine NOT OK");
      $finish;
    end
  end

  initial begin
    test_reset();
    test_directed();
    test_capacity();
    test_random_sets(0, 12);
    test_random_sets(59, 12);
    test_random_sets(8, 12);
    if (sorted_due.size() != 0 || gathered_set.size() != 0) begin
      fail_count++;
      $display("Values still owed at the end: %0d", sorted_due.size());
    end
    $display("Sorted %0d sets from %0d items, %0d values checked, including an overfull set.",
             sets_sent, items_sent, values_seen);
    $display("Sender ran back to back, with frequent gaps and with light gaps; failures: %0d.",
             fail_count);
    if (fail_count == 0) begin
      $display("tb_quick_sort_engine OK");
    end else begin
      $display("tb_quick_sort_engine NOT OK");
    end
    $finish;
  end

endmodule
